// ===== rtl/core/cli_pkg.sv =====
// Shared types and constants of the clamped linear interpolator.
package cli_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_FIRST = 2'd1;
  localparam logic [1:0] CLAMP_LAST  = 2'd2;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 7'd2;

  typedef struct packed {
    logic                     func;
    logic [INDEX_W-1:0]       point_index;
    logic signed [DATA_W-1:0] point_coordinate;
    logic signed [DATA_W-1:0] point_value;
    logic signed [DATA_W-1:0] query_position;
    logic                     batch_start;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               clamp_status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_CHK_SEG,
    ST_CHK_NEXT,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_SEG_START,
    ADDR_SEG_INC1,
    ADDR_SEG_INC2
  } addr_sel_e;

  typedef enum logic [1:0] {
    SEG_HOLD,
    SEG_ZERO,
    SEG_START,
    SEG_INC
  } seg_sel_e;

  typedef enum logic [2:0] {
    RES_RD_FIRST,
    RES_RD_LAST,
    RES_SAVED_LAST,
    RES_LEFT,
    RES_LERP
  } res_sel_e;

  typedef struct packed {
    logic      accept;
    logic      wr;
    addr_sel_e addr_sel;
    seg_sel_e  seg_sel;
    logic      lo_load;
    logic      last_load;
    logic      prep;
    logic      mul;
    logic      div_step;
    logic      emit;
    res_sel_e  res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic q_lt_rd;
    logic q_gt_rd;
    logic q_ge_lo;
    logic zero_width;
    logic seg_end;
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/core/clamped_linear_interpolator.sv =====
// Top level of the clamped piecewise-linear interpolator.
//
// Requests enter on req_i, taken at a clock edge with start high and busy low.
// A load request writes one breakpoint (coordinate, value) and gives no result;
// busy stays low, so the next request may follow in the next cycle.
// A query request gives one result on result_o, marked by done_o for exactly
// one cycle; the receiver cannot stall, it must take the result then.
// A query first compares with the first point and is clamped to it if not above
//   it, then with the last point and is clamped to it if not below it; else the
//   search restarts at segment 0 when the query lies below the saved segment,
//   and steps over segments until a zero-width or enclosing one or the end;
//   an enclosing segment is interpolated by a 32x32 multiply and 32-step divide.
// busy drops in the done_o cycle, so the next request may be taken there.
// The table sits in one RAM with one read port, so the search reads one
// breakpoint per cycle and continues from the segment found last.
// The breakpoint count is written on the cfg channel (cfg_ready_o is high
// while idle). Reset sets the count to 2 and the search segment to 0; the
// table itself is not cleared and must be loaded before it is queried.
module clamped_linear_interpolator #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  cli_pkg::req_t               req_i,
  output logic                        done_o,
  output cli_pkg::rsp_t               result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cli_pkg::COUNT_W-1:0] cfg_data_i
);

  cli_pkg::cmd_t cmd;
  cli_pkg::sts_t sts;
  logic          cfg_we;

  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cli_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy  (busy)
  );

  cli_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

// ===== rtl/core/cli_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cli_ctrl.sv =====
// Sequencer for table search, clamping and the multiply-divide of one request.
module cli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  cli_pkg::sts_t sts_i,
  output cli_pkg::cmd_t cmd_o,
  output logic          busy
);

  cli_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cli_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cli_pkg::ST_IDLE: begin
        if (start && sts_i.is_query) begin
          state_d = cli_pkg::ST_CHK_FIRST;
        end
      end
      cli_pkg::ST_CHK_FIRST: begin
        state_d = sts_i.q_gt_rd ? cli_pkg::ST_CHK_LAST : cli_pkg::ST_IDLE;
      end
      cli_pkg::ST_CHK_LAST: begin
        state_d = sts_i.q_lt_rd ? cli_pkg::ST_CHK_SEG : cli_pkg::ST_IDLE;
      end
      cli_pkg::ST_CHK_SEG: begin
        if (!sts_i.q_lt_rd) begin
          state_d = cli_pkg::ST_CHK_NEXT;
        end
      end
      cli_pkg::ST_CHK_NEXT: begin
        priority if (sts_i.q_ge_lo && !sts_i.q_gt_rd) begin
          state_d = sts_i.zero_width ? cli_pkg::ST_IDLE : cli_pkg::ST_MUL;
        end else if (sts_i.seg_end) begin
          state_d = cli_pkg::ST_IDLE;
        end else begin
          state_d = cli_pkg::ST_CHK_NEXT;
        end
      end
      cli_pkg::ST_MUL: begin
        state_d = cli_pkg::ST_DIV;
      end
      cli_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = cli_pkg::ST_FIN;
        end
      end
      cli_pkg::ST_FIN: begin
        state_d = cli_pkg::ST_IDLE;
      end
      default: begin
        state_d = cli_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = cli_pkg::ADDR_ZERO;
    cmd_o.seg_sel  = cli_pkg::SEG_HOLD;
    cmd_o.res_sel  = cli_pkg::RES_LERP;
    unique case (state_q)
      cli_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          cmd_o.wr     = !sts_i.is_query;
        end
      end
      cli_pkg::ST_CHK_FIRST: begin
        if (sts_i.q_gt_rd) begin
          cmd_o.addr_sel = cli_pkg::ADDR_LAST;
        end else begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = cli_pkg::RES_RD_FIRST;
        end
      end
      cli_pkg::ST_CHK_LAST: begin
        if (sts_i.q_lt_rd) begin
          cmd_o.last_load = 1'b1;
          cmd_o.seg_sel   = cli_pkg::SEG_START;
          cmd_o.addr_sel  = cli_pkg::ADDR_SEG_START;
        end else begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = cli_pkg::RES_RD_LAST;
        end
      end
      cli_pkg::ST_CHK_SEG: begin
        if (sts_i.q_lt_rd) begin
          cmd_o.seg_sel  = cli_pkg::SEG_ZERO;
          cmd_o.addr_sel = cli_pkg::ADDR_ZERO;
        end else begin
          cmd_o.lo_load  = 1'b1;
          cmd_o.addr_sel = cli_pkg::ADDR_SEG_INC1;
        end
      end
      cli_pkg::ST_CHK_NEXT: begin
        priority if (sts_i.q_ge_lo && !sts_i.q_gt_rd) begin
          if (sts_i.zero_width) begin
            cmd_o.emit    = 1'b1;
            cmd_o.res_sel = cli_pkg::RES_LEFT;
          end else begin
            cmd_o.prep = 1'b1;
          end
        end else if (sts_i.seg_end) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = cli_pkg::RES_SAVED_LAST;
        end else begin
          cmd_o.seg_sel  = cli_pkg::SEG_INC;
          cmd_o.lo_load  = 1'b1;
          cmd_o.addr_sel = cli_pkg::ADDR_SEG_INC2;
        end
      end
      cli_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      cli_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      cli_pkg::ST_FIN: begin
        cmd_o.emit    = 1'b1;
        cmd_o.res_sel = cli_pkg::RES_LERP;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
  end

  assign busy = (state_q != cli_pkg::ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == cli_pkg::ST_IDLE)
    else $error("controller did not return to idle after a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cli_pkg::ST_DIV && !sts_i.div_done) |=> state_q == cli_pkg::ST_DIV)
    else $error("division left before its last step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> state_q == cli_pkg::ST_IDLE)
    else $error("request taken while busy");

endmodule

// ===== rtl/core/cli_datapath.sv =====
// Breakpoint table, search registers, multiplier, restoring divider and result register.
module cli_datapath #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cli_pkg::req_t                   req_i,
  input  logic                            cfg_we_i,
  input  logic [cli_pkg::COUNT_W-1:0]     cfg_data_i,
  input  cli_pkg::cmd_t                   cmd_i,
  output cli_pkg::sts_t                   sts_o,
  output logic                            done_o,
  output cli_pkg::rsp_t                   result_o
);

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned DW    = cli_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DW);

  logic [cli_pkg::COUNT_W-1:0] pcount_q;
  logic [AW-1:0]               seg_q, seg_d;
  logic [AW-1:0]               last;
  logic [AW-1:0]               raddr;
  logic                        stale;
  logic                        wr_en;
  logic [2*DW-1:0]             rdata;
  logic signed [DW-1:0]        rd_coord, rd_value;
  logic signed [DW-1:0]        q_q, x_lo_q, v_lo_q, v_last_q;
  logic [DW-1:0]               dq_q, dw_q, dv_q;
  logic                        neg_q;
  logic signed [DW:0]          vdiff;
  logic [DW:0]                 vabs;
  logic [2*DW-1:0]             acc_q, acc_d;
  logic [2*DW-1:0]             prod;
  logic [DW:0]                 shifted, diff;
  logic [CNT_W-1:0]            cnt_q;
  logic signed [DW-1:0]        lerp;
  cli_pkg::rsp_t               rsp_q, rsp_d;
  logic                        done_q;

  always_comb begin
    priority if (pcount_q == '0) begin
      last = '0;
    end else if (32'(pcount_q) > MAX_POINTS) begin
      last = AW'(MAX_POINTS - 1);
    end else begin
      last = AW'(pcount_q - 7'd1);
    end
  end

  assign stale = ({1'b0, seg_q} >= {1'b0, last});

  always_comb begin
    unique case (cmd_i.addr_sel)
      cli_pkg::ADDR_ZERO:      raddr = '0;
      cli_pkg::ADDR_LAST:      raddr = last;
      cli_pkg::ADDR_SEG_START: raddr = stale ? '0 : seg_q;
      cli_pkg::ADDR_SEG_INC1:  raddr = seg_q + AW'(1);
      cli_pkg::ADDR_SEG_INC2:  raddr = seg_q + AW'(2);
      default:                 raddr = '0;
    endcase
  end

  assign wr_en = cmd_i.wr && (32'(req_i.point_index) < MAX_POINTS);

  cli_ram #(
    .WIDTH(2 * DW),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(AW'(req_i.point_index)),
    .wdata_i({req_i.point_coordinate, req_i.point_value}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_coord = rdata[2*DW-1:DW];
  assign rd_value = rdata[DW-1:0];

  always_comb begin
    seg_d = seg_q;
    priority if (cmd_i.accept && req_i.batch_start) begin
      seg_d = '0;
    end else begin
      unique case (cmd_i.seg_sel)
        cli_pkg::SEG_HOLD:  seg_d = seg_q;
        cli_pkg::SEG_ZERO:  seg_d = '0;
        cli_pkg::SEG_START: seg_d = stale ? '0 : seg_q;
        cli_pkg::SEG_INC:   seg_d = seg_q + AW'(1);
        default:            seg_d = seg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= cli_pkg::POINT_COUNT_RESET;
      seg_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pcount_q <= cfg_data_i;
      end
      seg_q  <= seg_d;
      done_q <= cmd_i.emit;
    end
  end

  assign vdiff = {rd_value[DW-1], rd_value} - {v_lo_q[DW-1], v_lo_q};
  assign vabs  = vdiff[DW] ? (~vdiff + 1'b1) : vdiff;
  assign prod  = dq_q * dv_q;

  assign shifted = {acc_q[2*DW-1:DW], acc_q[DW-1]};
  assign diff    = shifted - {1'b0, dw_q};

  always_comb begin
    if (!diff[DW]) begin
      acc_d = {diff[DW-1:0], acc_q[DW-2:0], 1'b1};
    end else begin
      acc_d = {shifted[DW-1:0], acc_q[DW-2:0], 1'b0};
    end
  end

  assign lerp = neg_q ? (v_lo_q - acc_q[DW-1:0]) : (v_lo_q + acc_q[DW-1:0]);

  always_comb begin
    unique case (cmd_i.res_sel)
      cli_pkg::RES_RD_FIRST: rsp_d = '{result_value: rd_value, clamp_status: cli_pkg::CLAMP_FIRST};
      cli_pkg::RES_RD_LAST:  rsp_d = '{result_value: rd_value, clamp_status: cli_pkg::CLAMP_LAST};
      cli_pkg::RES_SAVED_LAST:
        rsp_d = '{result_value: v_last_q, clamp_status: cli_pkg::CLAMP_LAST};
      cli_pkg::RES_LEFT:     rsp_d = '{result_value: v_lo_q, clamp_status: cli_pkg::CLAMP_NONE};
      cli_pkg::RES_LERP:     rsp_d = '{result_value: lerp, clamp_status: cli_pkg::CLAMP_NONE};
      default:               rsp_d = '{result_value: lerp, clamp_status: cli_pkg::CLAMP_NONE};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      q_q <= req_i.query_position;
    end
    if (cmd_i.lo_load) begin
      x_lo_q <= rd_coord;
      v_lo_q <= rd_value;
    end
    if (cmd_i.last_load) begin
      v_last_q <= rd_value;
    end
    if (cmd_i.prep) begin
      dq_q  <= q_q - x_lo_q;
      dw_q  <= rd_coord - x_lo_q;
      dv_q  <= vabs[DW-1:0];
      neg_q <= vdiff[DW];
    end
    if (cmd_i.mul) begin
      acc_q <= prod;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      acc_q <= acc_d;
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.is_query   = (req_i.func == cli_pkg::FUNC_QUERY);
  assign sts_o.q_lt_rd    = (q_q < rd_coord);
  assign sts_o.q_gt_rd    = (q_q > rd_coord);
  assign sts_o.q_ge_lo    = (q_q >= x_lo_q);
  assign sts_o.zero_width = (rd_coord <= x_lo_q);
  assign sts_o.seg_end    = (({1'b0, seg_q} + 1'b1) >= {1'b0, last});
  assign sts_o.div_done   = (cnt_q == CNT_W'(DW - 1));

  assign done_o   = done_q;
  assign result_o = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.emit))
    else $error("result strobe without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |=> cnt_q == '0)
    else $error("divider count not cleared at product load");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rsp_q.clamp_status == cli_pkg::CLAMP_NONE ||
                rsp_q.clamp_status == cli_pkg::CLAMP_FIRST ||
                rsp_q.clamp_status == cli_pkg::CLAMP_LAST))
    else $error("result carries a reserved clamp status");

endmodule
